// ----- src/ffid_pkg.sv -----
// Shared types and constants for the first-free identifier allocator.
package ffid_pkg;

  // Default identifier space and the two identifier limits
  localparam int          ID_SPACE_DEF = 65536;
  localparam logic [15:0] U8_MAX       = 16'd255;
  localparam logic [15:0] U16_MAX      = 16'd65535;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Input beat
  typedef struct packed {
    logic        req_type;
    logic [15:0] free_id;
  } ffid_in_t;

  // Result beat
  typedef struct packed {
    logic [15:0] granted_id;
    logic        exhausted;
  } ffid_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ptr_clr;   // reset word pointer
    logic ptr_inc;   // advance word pointer
    logic clr_wr;    // write clear value at pointer
    logic req_ld;    // capture input beat
    logic rd_free;   // read the word of the freed id (else pointer word)
    logic wr_free;   // write back word with freed bit cleared
    logic wr_set;    // write back word with found bit set
    logic hit_ld;    // capture found bit index
    logic out_ld;    // load result register
    logic out_none;  // result is the exhausted answer
  } ffid_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // pointer at last map word during clear
    logic free_ok;   // captured free id is in 1..limit
    logic hit;       // current scanned word has a free id in range
    logic scan_last; // pointer at the word holding the limit
    logic out_busy;  // result register cannot take a new beat
  } ffid_sts_t;

endpackage

// ----- src/first_free_id_allocator.sv -----
// Top level of the first-free identifier allocator.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | ffid_in_t  {req_type, free_id}
//  out_    | output    | out_valid/out_ready | ffid_out_t {granted_id, exhausted}
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data = wide_ids
//
// One item at a time. The map is held as 32-bit words in a memory with one read
// and one write port, and an allocate reads and tests one word at a time, first a
// read state and then an evaluate state, scanning up to 8 words with narrow ids
// and up to ID_SPACE/32 wide; a grant ends with a write that sets the found bit.
// A free is a read-modify-write of one word; an ignored free skips the write.
// After reset a clearing pass over every map word runs before in_ready rises;
// cfg_ready is always high. A stalled result waits in the output register.
module first_free_id_allocator #(
  parameter int ID_SPACE = ffid_pkg::ID_SPACE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffid_pkg::ffid_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffid_pkg::ffid_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import ffid_pkg::*;

  ffid_cmd_t cmd;
  ffid_sts_t sts;

  assign cfg_ready = 1'b1;

  ffid_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_free (in_data.req_type == REQ_FREE),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  ffid_dpath #(
    .ID_SPACE (ID_SPACE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // One item at a time: an accepted beat drops ready
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item was in progress");

  // A bit is only set after the scan found a free one
  a_set_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_set |-> $past(sts.hit))
    else $error("map bit set without a found free id");

  // Exhausted results carry id zero, granted ones never do
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.exhausted) |-> (out_data.granted_id == 16'd0))
    else $error("exhausted result with nonzero id");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.exhausted) |-> (out_data.granted_id != 16'd0))
    else $error("granted id zero");

endmodule

// ----- src/ffid_ctrl.sv -----
// Controller state machine: clear pass, free read-modify-write, allocate scan.
module ffid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_free,
  output logic              in_ready,
  input  ffid_pkg::ffid_sts_t sts,
  output ffid_pkg::ffid_cmd_t cmd
);
  import ffid_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SET_WR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   none_r, none_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    none_nxt  = none_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_ld  = 1'b1;
          cmd.ptr_clr = 1'b1;
          none_nxt    = 1'b0;
          state_nxt   = in_req_free ? S_FREE_RD : S_SCAN_RD;
        end
      end
      S_FREE_RD: begin
        // ids of zero or above the limit are dropped here
        if (sts.free_ok) begin
          cmd.rd_free = 1'b1;
          state_nxt   = S_FREE_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FREE_WR: begin
        cmd.wr_free = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (sts.hit) begin
          cmd.hit_ld = 1'b1;
          state_nxt  = S_SET_WR;
        end else if (sts.scan_last) begin
          none_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SET_WR: begin
        cmd.wr_set = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_ld   = 1'b1;
          cmd.out_none = none_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      none_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      none_r  <= none_nxt;
    end
  end

endmodule

// ----- src/ffid_dpath.sv -----
// Datapath: word-wide used map memory, word pointer, bit search and result register.
module ffid_dpath #(
  parameter int ID_SPACE = ffid_pkg::ID_SPACE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffid_pkg::ffid_in_t  in_data,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output ffid_pkg::ffid_out_t out_data,
  input  ffid_pkg::ffid_cmd_t cmd,
  output ffid_pkg::ffid_sts_t sts
);
  import ffid_pkg::*;

  localparam int MAP_WORDS = (ID_SPACE + 31) / 32;
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam logic [15:0] LIM_WIDE =
    (ID_SPACE - 1 < int'(U16_MAX)) ? 16'(ID_SPACE - 1) : U16_MAX;

  logic [31:0]        mem [MAP_WORDS];
  logic [31:0]        rd_data_r;
  logic [WORD_AW-1:0] ptr_r;
  logic [15:0]        req_id_r;
  logic [4:0]         hit_bit_r;
  logic               wide_r;
  logic               out_valid_r;
  ffid_out_t          out_data_r;

  logic [15:0]        lim;
  logic [WORD_AW-1:0] lim_word;
  logic [4:0]         lim_bit;
  logic [WORD_AW-1:0] fword;
  logic [4:0]         fbit;
  logic [31:0]        mask;
  logic [31:0]        cand;
  logic [4:0]         low_bit;
  logic               we;
  logic [WORD_AW-1:0] waddr;
  logic [31:0]        wdata;
  logic [WORD_AW-1:0] raddr;

  // Current limit and where it falls in the map
  assign lim      = wide_r ? LIM_WIDE : U8_MAX;
  assign lim_word = WORD_AW'(lim >> 5);
  assign lim_bit  = lim[4:0];
  assign fword    = WORD_AW'(req_id_r >> 5);
  assign fbit     = req_id_r[4:0];

  // Free ids in the scanned word, bits past the limit masked off
  always_comb begin
    for (int b = 0; b < 32; b++) begin
      mask[b] = (ptr_r != lim_word) || (5'(b) <= lim_bit);
    end
    cand = ~rd_data_r & mask;
  end

  // Lowest free bit
  always_comb begin
    low_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (cand[i]) low_bit = 5'(i);
    end
  end

  // Memory write port select
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = '0;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      wdata = (ptr_r == '0) ? 32'h1 : 32'h0;
    end else if (cmd.wr_free) begin
      we    = 1'b1;
      waddr = fword;
      wdata = rd_data_r & ~(32'h1 << fbit);
    end else if (cmd.wr_set) begin
      we    = 1'b1;
      wdata = rd_data_r | (32'h1 << hit_bit_r);
    end
  end

  assign raddr = cmd.rd_free ? fword : ptr_r;

  // Used map memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data_r <= mem[raddr];
  end

  // Pointer and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      wide_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ptr_clr)      ptr_r <= '0;
      else if (cmd.ptr_inc) ptr_r <= ptr_r + WORD_AW'(1);
      if (cfg_valid) wide_r <= cfg_data;
      if (cmd.out_ld)                   out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.req_ld) req_id_r  <= in_data.free_id;
    if (cmd.hit_ld) hit_bit_r <= low_bit;
    if (cmd.out_ld) begin
      out_data_r.granted_id <= cmd.out_none ? 16'd0 : 16'({ptr_r, hit_bit_r});
      out_data_r.exhausted  <= cmd.out_none;
    end
  end

  // Status
  assign sts.clr_last  = (ptr_r == WORD_AW'(MAP_WORDS - 1));
  assign sts.free_ok   = (req_id_r != 16'd0) && (req_id_r <= lim);
  assign sts.hit       = |cand;
  assign sts.scan_last = (ptr_r == lim_word);
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
